### hdl/pmc_pkg.sv
// Package for the path mount classifier: row table, payload types and codes.
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int TABLE_LEN      = 21;
  localparam int NUM_ROWS_DEF   = 21;
  localparam int NUM_DESC_DEF   = 128;
  localparam int POS_W          = 4;
  localparam int TEXT_BYTES     = 16;
  localparam int ROW_IDX_W      = 5;
  localparam int MINOR_W        = 7;

  localparam int FD_DIR_ROW     = 12;
  localparam int TTY_ROW        = 13;
  localparam int STDIN_ROW      = 14;
  localparam int STDOUT_ROW     = 15;
  localparam int STDERR_ROW     = 16;

  localparam logic [MINOR_W-1:0] MINOR_STDIN  = 7'd0;
  localparam logic [MINOR_W-1:0] MINOR_STDOUT = 7'd1;
  localparam logic [MINOR_W-1:0] MINOR_STDERR = 7'd2;
  localparam logic [MINOR_W-1:0] MINOR_TTY    = 7'd3;

  typedef enum logic [1:0] {
    FS_HOST = 2'd0,
    FS_PASS = 2'd1,
    FS_DESC = 2'd2,
    FS_PROC = 2'd3
  } fs_kind_t;

  typedef logic [TEXT_BYTES-1:0][7:0] row_bytes_t;

  // Row text, right-aligned in the vector: the first character is the highest used byte.
  localparam logic [127:0] ROW_TEXT [TABLE_LEN] = '{
    "/usr/lib/", "/usr/share/", "/usr/dict/", "/lib/", "/usr/pub/", "/bin/",
    "/usr/bin/", "/etc/", "/usr/man/", "/usr/spool/", "/usr/src/", "/dev/fd",
    "/dev/fd/", "/dev/tty", "/dev/stdin", "/dev/stdout", "/dev/stderr", "/dev/",
    "/unix", "/proc/", "/proc"
  };

  localparam logic [POS_W-1:0] ROW_LEN [TABLE_LEN] = '{
    4'd9, 4'd11, 4'd10, 4'd5, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd11, 4'd9,
    4'd7, 4'd8, 4'd8, 4'd10, 4'd11, 4'd11, 4'd5, 4'd5, 4'd6, 4'd5
  };

  localparam logic ROW_EXACT [TABLE_LEN] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
  };

  localparam fs_kind_t ROW_KIND [TABLE_LEN] = '{
    FS_PASS, FS_PASS, FS_PASS, FS_PASS, FS_PASS, FS_PASS, FS_PASS, FS_PASS,
    FS_PASS, FS_PASS, FS_PASS, FS_PASS, FS_DESC, FS_DESC, FS_DESC, FS_DESC,
    FS_DESC, FS_PASS, FS_PASS, FS_PROC, FS_PROC
  };

  // Byte k of the row text at index k; zero beyond the row length.
  function automatic row_bytes_t row_bytes(input int row);
    row_bytes_t   b;
    logic [127:0] t;
    int           n;
    b = '0;
    t = ROW_TEXT[row];
    n = int'(ROW_LEN[row]);
    for (int k = 0; k < TEXT_BYTES; k++) begin
      if (k < n) begin
        b[k] = t[(n - 1 - k) * 8 +: 8];
      end
    end
    return b;
  endfunction

  typedef struct packed {
    logic [7:0] path_char;
    logic       last_char;
  } in_data_t;

  typedef struct packed {
    logic [1:0]           fs_kind;
    logic                 row_hit;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 minor_valid;
    logic [MINOR_W-1:0]   minor_number;
  } out_data_t;

  typedef struct packed {
    logic [TABLE_LEN-1:0] hits;
    logic                 fd_pfx_old;
    logic                 fd_pfx_new;
  } match_t;

  typedef struct packed {
    logic               valid;
    logic [MINOR_W-1:0] number;
  } minor_t;

endpackage

### hdl/path_mount_classifier.sv
// Top level of the path mount classifier: input register, match logic, result register.
`timescale 1ns / 1ps
// The final item of a path passes the input register, then the result register.
// Throughput: one item per cycle; the only stall is a held result with the next final
//   item waiting behind it in the input register.
// Reset (rst_n low, synchronous): empties both registers, clears path state and
//   proc_present; no clearing pass is needed.

module path_mount_classifier #(
  parameter int NUM_ROWS       = pmc_pkg::NUM_ROWS_DEF,
  parameter int NUM_DESC_NODES = pmc_pkg::NUM_DESC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pmc_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pmc_pkg::out_data_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic                  proc_present_r;
  logic                  s1_valid_r, s1_valid_nxt;
  pmc_pkg::in_data_t     s1_data_r;
  logic                  out_valid_r, out_valid_nxt;
  pmc_pkg::out_data_t    out_data_r, out_data_nxt;
  logic                  in_acc, advance;
  pmc_pkg::match_t       match;
  pmc_pkg::minor_t       minor;
  logic                  win_found;
  logic [pmc_pkg::ROW_IDX_W-1:0] win_idx;
  pmc_pkg::fs_kind_t     win_kind;

  // Advance the held item unless it is final and the result slot stays blocked.
  assign advance  = s1_valid_r && (!s1_data_r.last_char || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  pmc_row_match #(
    .NUM_ROWS (NUM_ROWS)
  ) u_row_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_data_r),
    .match (match)
  );

  pmc_minor_decode #(
    .NUM_DESC_NODES (NUM_DESC_NODES)
  ) u_minor_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_data_r),
    .match (match),
    .minor (minor)
  );

  // Pick the lowest-numbered matching row: scan down so the last hit written wins.
  always_comb begin
    win_found = 1'b0;
    win_idx   = '0;
    for (int i = pmc_pkg::TABLE_LEN - 1; i >= 0; i--) begin
      if (match.hits[i]) begin
        win_found = 1'b1;
        win_idx   = pmc_pkg::ROW_IDX_W'(i);
      end
    end
  end

  always_comb begin
    win_kind = pmc_pkg::ROW_KIND[win_idx];
    // Drop a process row when no process filesystem type exists.
    if (!win_found || (win_kind == pmc_pkg::FS_PROC && !proc_present_r)) begin
      win_kind = pmc_pkg::FS_HOST;
    end
    out_data_nxt.fs_kind      = win_kind;
    out_data_nxt.row_hit      = (win_kind != pmc_pkg::FS_HOST);
    out_data_nxt.row_index    = (win_kind != pmc_pkg::FS_HOST) ? win_idx : '0;
    out_data_nxt.minor_valid  = minor.valid;
    out_data_nxt.minor_number = minor.number;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_data_r.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_present_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        proc_present_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_data_r.last_char) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stall on the input side only comes from a final item behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_data_r.last_char && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_no_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.row_hit) |-> (out_data.row_index == '0))
    else $error("row index set without a row hit");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_hit == (out_data.fs_kind != pmc_pkg::FS_HOST)))
    else $error("row hit disagrees with filesystem kind");

  a_minor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.minor_valid) |-> (out_data.minor_number == '0))
    else $error("minor number set without a valid minor");

endmodule

### hdl/pmc_row_match.sv
// Per-row character compare with running equal and prefix flags.
`timescale 1ns / 1ps

module pmc_row_match #(
  parameter int NUM_ROWS = pmc_pkg::NUM_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  pmc_pkg::in_data_t item,
  output pmc_pkg::match_t  match
);

  localparam int ROWS = (NUM_ROWS < pmc_pkg::TABLE_LEN) ? NUM_ROWS : pmc_pkg::TABLE_LEN;

  logic [pmc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [ROWS-1:0]           eq_r, eq_nxt;
  logic [ROWS-1:0]           pfx_r, pfx_nxt;
  logic [pmc_pkg::TABLE_LEN-1:0] hits;
  logic [pmc_pkg::POS_W:0]   pos_p1, pos_p2;

  assign pos_p1 = {1'b0, pos_r} + 5'd1;
  assign pos_p2 = {1'b0, pos_r} + 5'd2;

  for (genvar i = 0; i < pmc_pkg::TABLE_LEN; i++) begin : g_row
    if (i < ROWS) begin : g_live
      localparam pmc_pkg::row_bytes_t TXT = pmc_pkg::row_bytes(i);
      localparam logic [pmc_pkg::POS_W:0] LEN = {1'b0, pmc_pkg::ROW_LEN[i]};
      logic eq, full;
      assign eq   = eq_r[i] && ({1'b0, pos_r} < LEN) && (item.path_char == TXT[pos_r]);
      assign full = eq && (pos_p1 == LEN);
      assign eq_nxt[i]  = eq;
      assign pfx_nxt[i] = pfx_r[i] || full;
      if (pmc_pkg::ROW_EXACT[i]) begin : g_exact
        assign hits[i] = full;
      end else begin : g_prefix
        // also take the directory spelled without its trailing slash
        assign hits[i] = pfx_r[i] || full || (eq && (pos_p2 == LEN));
      end
    end else begin : g_none
      assign hits[i] = 1'b0;
    end
  end

  assign pos_nxt = (pos_r == {pmc_pkg::POS_W{1'b1}}) ? pos_r : pos_r + 4'd1;

  assign match.hits = hits;
  if (pmc_pkg::FD_DIR_ROW < ROWS) begin : g_fd
    assign match.fd_pfx_old = pfx_r[pmc_pkg::FD_DIR_ROW];
    assign match.fd_pfx_new = pfx_nxt[pmc_pkg::FD_DIR_ROW];
  end else begin : g_no_fd
    assign match.fd_pfx_old = 1'b0;
    assign match.fd_pfx_new = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      eq_r  <= '1;
      pfx_r <= '0;
    end else if (step) begin
      if (item.last_char) begin
        pos_r <= '0;
        eq_r  <= '1;
        pfx_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        eq_r  <= eq_nxt;
        pfx_r <= pfx_nxt;
      end
    end
  end

endmodule

### hdl/pmc_minor_decode.sv
// Descriptor minor decode: named links and strict decimal after the fd prefix.
`timescale 1ns / 1ps

module pmc_minor_decode #(
  parameter int NUM_DESC_NODES = pmc_pkg::NUM_DESC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pmc_pkg::in_data_t item,
  input  pmc_pkg::match_t   match,
  output pmc_pkg::minor_t   minor
);

  localparam int AW = $clog2(NUM_DESC_NODES);
  localparam int PW = AW + 4;
  localparam int NW = (AW > pmc_pkg::MINOR_W) ? AW : pmc_pkg::MINOR_W;

  logic [AW-1:0] acc_r, acc_nxt;
  logic          ok_r, ok_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          lz_r, lz_nxt;
  logic          is_digit;
  logic [3:0]    digit;
  logic [PW-1:0] prod;
  logic [NW-1:0] acc_ext;

  assign is_digit = (item.path_char >= 8'h30) && (item.path_char <= 8'h39);
  assign digit    = item.path_char[3:0];
  assign prod     = PW'(acc_r) * PW'(10) + PW'(digit);
  assign acc_ext  = NW'(acc_nxt);

  always_comb begin
    acc_nxt = acc_r;
    ok_nxt  = ok_r;
    cnt_nxt = cnt_r;
    lz_nxt  = lz_r;
    if (match.fd_pfx_old) begin
      if (is_digit) begin
        if (cnt_r == 2'd0 && digit == 4'd0) begin
          lz_nxt = 1'b1;
        end else if (lz_r) begin
          ok_nxt = 1'b0;
        end
        if (ok_nxt) begin
          if (prod >= PW'(NUM_DESC_NODES)) begin
            ok_nxt = 1'b0;
          end else begin
            acc_nxt = AW'(prod);
          end
        end
        if (cnt_r != 2'd3) begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    minor.valid  = 1'b1;
    minor.number = '0;
    if (match.hits[pmc_pkg::STDIN_ROW]) begin
      minor.number = pmc_pkg::MINOR_STDIN;
    end else if (match.hits[pmc_pkg::STDOUT_ROW]) begin
      minor.number = pmc_pkg::MINOR_STDOUT;
    end else if (match.hits[pmc_pkg::STDERR_ROW]) begin
      minor.number = pmc_pkg::MINOR_STDERR;
    end else if (match.hits[pmc_pkg::TTY_ROW]) begin
      minor.number = pmc_pkg::MINOR_TTY;
    end else if (match.fd_pfx_new && ok_nxt && cnt_nxt != 2'd0) begin
      minor.number = acc_ext[pmc_pkg::MINOR_W-1:0];
    end else begin
      minor.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ok_r  <= 1'b1;
      cnt_r <= '0;
      lz_r  <= 1'b0;
    end else if (step) begin
      if (item.last_char) begin
        acc_r <= '0;
        ok_r  <= 1'b1;
        cnt_r <= '0;
        lz_r  <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        ok_r  <= ok_nxt;
        cnt_r <= cnt_nxt;
        lz_r  <= lz_nxt;
      end
    end
  end

endmodule

### tb/sv/path_mount_classifier_tb.sv
// Testbench for the path mount classifier: path stimulus, mount table predictor, result check.
`timescale 1ns / 1ps

module path_mount_classifier_tb;

  localparam int N_MOUNTS     = 21;
  localparam int FD_DIR       = 12;
  localparam int TTY_LINK     = 13;
  localparam int STDIN_LINK   = 14;
  localparam int STDOUT_LINK  = 15;
  localparam int STDERR_LINK  = 16;
  localparam int DESC_LIMIT   = 128;
  localparam int POS_SAT      = 15;
  localparam int DIGIT_SAT    = 3;
  localparam int IDLE_WAIT    = 4;       // final item passes the input register, then the result register
  localparam int DRAIN_WAIT   = 8;
  localparam int RANDOM_ITEMS = 736;
  localparam int RANDOM_PHASES = 4;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [7:0]         CHAR_ZERO  = 8'h30;
  localparam logic [7:0]         CHAR_NINE  = 8'h39;
  localparam pmc_pkg::out_data_t NO_MATCH   = '0;

  // Receiver behavior: open, light random stall, heavy random stall, solid hold.
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

  typedef struct {
    string              path;
    logic               proc;
    bit                 typed;
    pmc_pkg::out_data_t res;
  } probe_t;

  typedef struct {
    bit                 typed;
    pmc_pkg::out_data_t res;
  } typed_class_t;

  // Mount table, in priority order.
  string mount_text [N_MOUNTS] = '{
    "/usr/lib/", "/usr/share/", "/usr/dict/", "/lib/", "/usr/pub/", "/bin/",
    "/usr/bin/", "/etc/", "/usr/man/", "/usr/spool/", "/usr/src/", "/dev/fd",
    "/dev/fd/", "/dev/tty", "/dev/stdin", "/dev/stdout", "/dev/stderr", "/dev/",
    "/unix", "/proc/", "/proc"
  };
  bit mount_exact [N_MOUNTS] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 1, 1, 0, 1, 0, 1
  };
  pmc_pkg::fs_kind_t mount_kind [N_MOUNTS] = '{
    pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS,
    pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS,
    pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS,
    pmc_pkg::FS_DESC, pmc_pkg::FS_DESC, pmc_pkg::FS_DESC, pmc_pkg::FS_DESC,
    pmc_pkg::FS_DESC, pmc_pkg::FS_PASS, pmc_pkg::FS_PASS, pmc_pkg::FS_PROC,
    pmc_pkg::FS_PROC
  };

  // Directed paths. Rows marked typed carry a hand-written answer; the rest go
  // through the predictor.
  probe_t probes [26] = '{
    '{"x",              1'b0, 1'b1, NO_MATCH},
    '{"/",              1'b0, 1'b1, NO_MATCH},
    '{"/\377",          1'b0, 1'b1, NO_MATCH},
    '{"/usr/lib/x",     1'b0, 1'b1, {pmc_pkg::FS_PASS, 1'b1, 5'd0,  1'b0, 7'd0}},
    '{"/usr/lib",       1'b0, 1'b1, {pmc_pkg::FS_PASS, 1'b1, 5'd0,  1'b0, 7'd0}},
    '{"/dev/fd",        1'b0, 1'b1, {pmc_pkg::FS_PASS, 1'b1, 5'd11, 1'b0, 7'd0}},
    '{"/dev/fd/",       1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd12, 1'b0, 7'd0}},
    '{"/dev/fd/0",      1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd12, 1'b1, 7'd0}},
    '{"/dev/fd/127",    1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd12, 1'b1, 7'd127}},
    '{"/dev/fd/128",    1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd12, 1'b0, 7'd0}},
    '{"/dev/fd/01",     1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd12, 1'b0, 7'd0}},
    '{"/dev/fd/7x",     1'b0, 1'b0, NO_MATCH},
    '{"/dev/stdin",     1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd14, 1'b1, 7'd0}},
    '{"/dev/stdout",    1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd15, 1'b1, 7'd1}},
    '{"/dev/stderr",    1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd16, 1'b1, 7'd2}},
    '{"/dev/tty",       1'b0, 1'b1, {pmc_pkg::FS_DESC, 1'b1, 5'd13, 1'b1, 7'd3}},
    '{"/dev/ttyx",      1'b0, 1'b0, NO_MATCH},
    '{"/dev",           1'b0, 1'b0, NO_MATCH},
    '{"/unix",          1'b0, 1'b1, {pmc_pkg::FS_PASS, 1'b1, 5'd18, 1'b0, 7'd0}},
    '{"/proc",          1'b0, 1'b1, NO_MATCH},
    '{"/proc/self",     1'b0, 1'b1, NO_MATCH},
    '{"/proc",          1'b1, 1'b1, {pmc_pkg::FS_PROC, 1'b1, 5'd19, 1'b0, 7'd0}},
    '{"/proc/1",        1'b1, 1'b0, NO_MATCH},
    '{"/usr/src/aaaaaaaaaaaaaaaa/x", 1'b1, 1'b1,
      {pmc_pkg::FS_PASS, 1'b1, 5'd10, 1'b0, 7'd0}},
    '{"/dev/fd/1234567", 1'b1, 1'b0, NO_MATCH},
    '{"\001",           1'b1, 1'b1, NO_MATCH}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  pmc_pkg::in_data_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pmc_pkg::out_data_t out_data;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;

  // Predictor copy of the block state, at reset values.
  logic                proc_on    = 1'b0;
  logic [3:0]          char_pos   = '0;
  logic [N_MOUNTS-1:0] still_eq   = '1;
  logic [N_MOUNTS-1:0] pfx_hit    = '0;
  logic [6:0]          minor_acc  = '0;
  logic                digits_ok  = 1'b1;
  logic [1:0]          digit_cnt  = '0;
  logic                lead_zero  = 1'b0;

  pmc_pkg::out_data_t class_due_q [$];    // expected classifications, oldest first
  typed_class_t       typed_class_q [$];  // one per path: hand-written answer or none
  logic [7:0]         path_bytes [$];     // path being sent

  int unsigned cycle_count = 0;
  int          err_count   = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  rx_mode_t    stall_mode  = RX_OPEN;
  int          stall_left  = 0;

  path_mount_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("path_mount_classifier_tb failed");
    $finish;
  end

  // Advance the predictor by one character; report a classification on the final one.
  task automatic classify_char(input logic [7:0] c, input logic last, output bit done,
                               output pmc_pkg::out_data_t res);
    int                  p, len, n, d;
    logic [N_MOUNTS-1:0] nxt_eq, nxt_pfx, hits;
    bit                  eq, full, found;
    pmc_pkg::fs_kind_t   k;
    p       = int'(char_pos);
    nxt_eq  = '0;
    nxt_pfx = pfx_hit;
    hits    = '0;
    done    = 1'b0;
    res     = '0;
    found   = 1'b0;
    // Compare against every row in parallel; a prefix row also takes its
    // directory name without the trailing slash.
    for (int i = 0; i < N_MOUNTS; i++) begin
      len  = mount_text[i].len();
      eq   = still_eq[i] && (p < len) && (c == mount_text[i][p]);
      full = eq && (p + 1 == len);
      if (eq) nxt_eq[i] = 1'b1;
      if (full) nxt_pfx[i] = 1'b1;
      if (mount_exact[i]) begin
        hits[i] = full;
      end else begin
        hits[i] = pfx_hit[i] || full || (eq && (p + 2 == len));
      end
    end
    // Decode a strict decimal minor after the descriptor directory.
    if (pfx_hit[FD_DIR]) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = int'(c - CHAR_ZERO);
        if (digit_cnt == 0 && d == 0) begin
          lead_zero = 1'b1;
        end else if (lead_zero) begin
          digits_ok = 1'b0;
        end
        if (digits_ok) begin
          n = int'(minor_acc) * 10 + d;
          if (n >= DESC_LIMIT) digits_ok = 1'b0;
          else minor_acc = 7'(n);
        end
        if (digit_cnt < DIGIT_SAT) digit_cnt++;
      end else begin
        digits_ok = 1'b0;
      end
    end
    still_eq = nxt_eq;
    pfx_hit  = nxt_pfx;
    if (char_pos < POS_SAT) char_pos++;
    if (last) begin
      done = 1'b1;
      // First hit wins; a process row without its type still wins, as no match.
      for (int i = 0; i < N_MOUNTS; i++) begin
        if (!found && hits[i]) begin
          found = 1'b1;
          k = mount_kind[i];
          if (k == pmc_pkg::FS_PROC && !proc_on) k = pmc_pkg::FS_HOST;
          if (k != pmc_pkg::FS_HOST) begin
            res.fs_kind   = k;
            res.row_hit   = 1'b1;
            res.row_index = 5'(i);
          end
        end
      end
      if (hits[STDIN_LINK]) begin
        res.minor_valid  = 1'b1;
        res.minor_number = pmc_pkg::MINOR_STDIN;
      end else if (hits[STDOUT_LINK]) begin
        res.minor_valid  = 1'b1;
        res.minor_number = pmc_pkg::MINOR_STDOUT;
      end else if (hits[STDERR_LINK]) begin
        res.minor_valid  = 1'b1;
        res.minor_number = pmc_pkg::MINOR_STDERR;
      end else if (hits[TTY_LINK]) begin
        res.minor_valid  = 1'b1;
        res.minor_number = pmc_pkg::MINOR_TTY;
      end else if (pfx_hit[FD_DIR] && digits_ok && digit_cnt > 0) begin
        res.minor_valid  = 1'b1;
        res.minor_number = minor_acc;
      end
      // Drop all path state; proc_on is kept.
      char_pos  = '0;
      still_eq  = '1;
      pfx_hit   = '0;
      minor_acc = '0;
      digits_ok = 1'b1;
      digit_cnt = '0;
      lead_zero = 1'b0;
    end
  endtask

  // Predict on every accepted item; values seen here are the ones before the edge.
  always @(posedge clk) begin : watch_in
    bit                 done;
    pmc_pkg::out_data_t res;
    typed_class_t       tag;
    if (rst_n && in_valid && !in_stall) begin
      classify_char(in_data.path_char, in_data.last_char, done, res);
      if (done) begin
        tag = typed_class_q.pop_front();
        class_due_q.push_back(tag.typed ? tag.res : res);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin : watch_out
    pmc_pkg::out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (class_due_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
        err_count++;
      end else begin
        want = class_due_q.pop_front();
        check_field("fs_kind", want.fs_kind, out_data.fs_kind);
        check_field("row_hit", want.row_hit, out_data.row_hit);
        check_field("row_index", want.row_index, out_data.row_index);
        check_field("minor_valid", want.minor_valid, out_data.minor_valid);
        check_field("minor_number", want.minor_number, out_data.minor_number);
      end
    end
  end

  // Receiver: switch among open, light, heavy and solid-hold stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:  out_stall <= (stall_left > 20);
    endcase
  end

  // Present one item and hold it until taken; then maybe open a gap.
  task automatic drive_char(input logic [7:0] c, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{path_char: c, last_char: last};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        // long run with no gaps
        burst_left = $urandom_range(40, 120);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_path(input bit typed, input pmc_pkg::out_data_t res);
    typed_class_q.push_back('{typed: typed, res: res});
    for (int i = 0; i < path_bytes.size(); i++) begin
      drive_char(path_bytes[i], i == path_bytes.size() - 1);
    end
  endtask

  // Write proc_present only once the block has gone idle.
  task automatic set_proc(input logic v);
    in_valid <= 1'b0;
    // let the last accepted item reach the expectation queue
    @(posedge clk);
    while (class_due_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    proc_on = v;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) path_bytes.push_back(s[i]);
  endtask

  // Append n characters, mostly path-like, sometimes any nonzero byte.
  task automatic add_tail(input int n);
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyz0123456789/._-";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) path_bytes.push_back(8'($urandom_range(1, 255)));
      else path_bytes.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    end
  endtask

  // Build one random path: mostly row-shaped, some descriptor names, some noise.
  task automatic build_random_path;
    int    mode, row, n;
    string base;
    path_bytes.delete();
    mode = $urandom_range(0, 99);
    row  = $urandom_range(0, N_MOUNTS - 1);
    base = mount_text[row];
    if (mode < 50) begin
      case ($urandom_range(0, 2))
        0: push_text(base);
        1: push_text(base.substr(0, base.len() - 2));
        default: begin
          push_text(base);
          add_tail($urandom_range(1, 6));
        end
      endcase
    end else if (mode < 68) begin
      n = $urandom_range(0, 199);
      case ($urandom_range(0, 5))
        0: push_text($sformatf("/dev/fd/0%0d", n));
        1: push_text($sformatf("/dev/fd/%0dx", n));
        2: push_text($sformatf("/dev/fd/%0d", $urandom_range(1000, 99999)));
        default: push_text($sformatf("/dev/fd/%0d", n));
      endcase
    end else if (mode < 80) begin
      push_text(base);
      if ($urandom_range(0, 1) == 0) begin
        path_bytes[$urandom_range(0, path_bytes.size() - 1)] = 8'($urandom_range(1, 255));
      end else begin
        n = $urandom_range(1, path_bytes.size() - 1);
        while (path_bytes.size() > n) void'(path_bytes.pop_back());
      end
    end else if (mode < 90) begin
      push_text(base);
      add_tail($urandom_range(8, 14));
    end else begin
      if ($urandom_range(0, 1) == 0) path_bytes.push_back("/");
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) path_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  initial begin : run
    int base_items;
    // Hold reset at the start, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed paths, with proc_present changed between groups.
    foreach (probes[k]) begin
      if (probes[k].proc != proc_on) set_proc(probes[k].proc);
      path_bytes.delete();
      push_text(probes[k].path);
      send_path(probes[k].typed, probes[k].res);
    end

    // Random phases, flipping proc_present at each.
    base_items = items_sent;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_proc(ph[0]);
      while (items_sent < base_items + (ph + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        build_random_path();
        send_path(1'b0, NO_MATCH);
      end
    end

    // Drain, then give a stray result time to show up.
    in_valid <= 1'b0;
    @(posedge clk);
    while (class_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("path_mount_classifier_tb passed");
    end else begin
      $display("path_mount_classifier_tb failed");
    end
    $finish;
  end

endmodule
